### rtl/core/assert_macros.svh
// Assertion macros shared by the restart limit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/lrl_pkg.sv
// Shared constants and types for the restart conflict limit block.
package lrl_pkg;

    // Field widths
    localparam int GF_BITS       = 16;
    localparam int BASE_BITS     = 20;
    localparam int CFG_BITS      = 20;
    localparam int EXP_OUT_BITS  = 16;
    localparam int IDX_IN_BITS   = 16;
    localparam int LIMIT_BITS    = 31;
    localparam int MUL_BITS      = 20;

    // Parameter defaults
    localparam int DEF_INDEX_BITS = 16;
    localparam int DEF_FRAC_BITS  = 12;

    // Register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LUBY_MODE = 2'd0;
    localparam t_cfg_idx CFG_BASE      = 2'd1;
    localparam t_cfg_idx CFG_GROWTH    = 2'd2;

    // Reset values
    localparam logic                 RST_LUBY_MODE = 1'b1;
    localparam logic [BASE_BITS-1:0] RST_BASE      = 20'd100;
    localparam logic [GF_BITS-1:0]   RST_GROWTH    = 16'd8192;

    // Largest limit, 2^31-1
    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = {LIMIT_BITS{1'b1}};

endpackage

### rtl/core/lrl_luby.sv
// Luby exponent finder: one grow or reduce step per cycle.
`include "assert_macros.svh"

module lrl_luby
    import lrl_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_luby_mode,
    input  logic [INDEX_BITS-1:0] i_index,
    output logic                  o_done,
    output logic [INDEX_BITS-1:0] o_exponent
);

    localparam logic [1:0] L_IDLE   = 2'd0;
    localparam logic [1:0] L_GROW   = 2'd1;
    localparam logic [1:0] L_REDUCE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic                  r_done, n_done;
    logic [INDEX_BITS-1:0] r_x, n_x;
    logic [INDEX_BITS:0]   r_size, n_size;
    logic [INDEX_BITS-1:0] r_seq, n_seq;
    logic [INDEX_BITS:0]   w_half;
    logic [INDEX_BITS:0]   w_x_ext;

    assign w_x_ext = {1'b0, r_x};
    assign w_half  = r_size >> 1;

    // Step the subsequence search
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_x     = r_x;
        n_size  = r_size;
        n_seq   = r_seq;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    if (i_luby_mode) begin
                        n_x     = i_index;
                        n_size  = (INDEX_BITS+1)'(1);
                        n_seq   = '0;
                        n_state = L_GROW;
                    end else begin
                        n_seq  = i_index;
                        n_done = 1'b1;
                    end
                end
            end
            L_GROW: begin
                // widen until the subsequence holds the index
                if (w_x_ext >= r_size) begin
                    n_size = {r_size[INDEX_BITS-1:0], 1'b1};
                    n_seq  = r_seq + 1'b1;
                end else begin
                    n_state = L_REDUCE;
                end
            end
            L_REDUCE: begin
                if (r_size - 1'b1 == w_x_ext) begin
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end else begin
                    // halve and take the remainder by one compare and subtract
                    n_size = w_half;
                    n_seq  = r_seq - 1'b1;
                    if (w_half == '0) begin
                        n_done  = 1'b1;
                        n_state = L_IDLE;
                    end else if (w_x_ext >= w_half) begin
                        n_x = r_x - w_half[INDEX_BITS-1:0];
                    end
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x    <= n_x;
        r_size <= n_size;
        r_seq  <= n_seq;
    end

    assign o_done     = r_done;
    assign o_exponent = r_seq;

    `ASSERT_CLK(a_reduce_in_range, i_clk, i_rst_n, (r_state == L_REDUCE) |-> (r_size > w_x_ext), "luby index left its subsequence")

endmodule

### rtl/core/lrl_smul.sv
// Serial shift-add multiplier: one multiplier bit per cycle, LSB first.
`include "assert_macros.svh"

module lrl_smul
    import lrl_pkg::*;
#(
    parameter int ACC_W = DEF_FRAC_BITS + 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ACC_W-1:0]          i_a,
    input  logic [MUL_BITS-1:0]       i_b,
    output logic                      o_done,
    output logic [ACC_W+MUL_BITS-1:0] o_prod
);

    localparam int PW = ACC_W + MUL_BITS;
    localparam int CW = $clog2(MUL_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [ACC_W-1:0]    r_a;
    logic [MUL_BITS-1:0] r_mlt;
    logic [PW-1:0]       r_prod;
    logic [ACC_W:0]      w_sum;

    // Add the multiplicand into the upper half when the current bit is set
    assign w_sum = {1'b0, r_prod[PW-1:MUL_BITS]} + (r_mlt[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        // load operands, then shift the product right one bit per step
        if (i_start) begin
            r_a    <= i_a;
            r_mlt  <= i_b;
            r_prod <= '0;
        end else if (r_busy) begin
            r_mlt  <= r_mlt >> 1;
            r_prod <= {w_sum, r_prod[MUL_BITS-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

    `ASSERT_CLK(a_no_start_busy, i_clk, i_rst_n, r_busy |-> !i_start, "multiply started while busy")

endmodule

### rtl/core/luby_restart_limit_top.sv
// Top level of the restart conflict limit generator.
// Each request takes a restart index and returns one conflict limit, the
// exponent used and a saturation flag; one request is worked on at a time.
// A request's result turns valid in the cycle before the earliest edge that
// can accept the next one. The Luby exponent search makes one grow or
// reduce step per cycle; in geometric mode the index is the exponent. The
// growth factor multiplications number at most the exponent, and they end
// early once the power reaches the 2^31 cap or stops changing. Each
// multiplication runs on one serial shift-add unit that consumes one
// multiplier bit per cycle (MUL_BITS = 20). A finished result waits in an
// output register while the next request is taken. If that register is
// still full when the next result is ready, the block holds the input
// stalled until the register frees up.
`include "assert_macros.svh"

module luby_restart_limit_top
    import lrl_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration writes
    input  logic                    i_cfg_we,
    input  t_cfg_idx                i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    // request side
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [IDX_IN_BITS-1:0]  i_restart_index,
    // result side
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [LIMIT_BITS-1:0]   o_conflict_limit,
    output logic [EXP_OUT_BITS-1:0] o_exponent,
    output logic                    o_saturated
);

    localparam int ACC_W = FRAC_BITS + 32;
    localparam int PW    = ACC_W + MUL_BITS;
    localparam int EXT_W = (INDEX_BITS > IDX_IN_BITS) ? INDEX_BITS : IDX_IN_BITS;
    localparam int XW    = (EXT_W > EXP_OUT_BITS) ? EXT_W : EXP_OUT_BITS;

    localparam logic [ACC_W-1:0] ACC_ONE = {{(ACC_W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [ACC_W-1:0] ACC_CAP =
        {{(ACC_W-1){1'b0}}, 1'b1} << (LIMIT_BITS + FRAC_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXP  = 3'd1;
    localparam logic [2:0] S_PCHK = 3'd2;
    localparam logic [2:0] S_PMUL = 3'd3;
    localparam logic [2:0] S_LMUL = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]             r_state;
    logic                   r_luby_mode;
    logic [BASE_BITS-1:0]   r_base;
    logic [GF_BITS-1:0]     r_gf;
    logic [ACC_W-1:0]       r_acc;
    logic [INDEX_BITS-1:0]  r_cnt;
    logic [INDEX_BITS-1:0]  r_exp;
    logic [LIMIT_BITS-1:0]  r_lim;
    logic                   r_sat;
    logic                   r_out_valid;
    logic [LIMIT_BITS-1:0]  r_out_limit;
    logic [EXP_OUT_BITS-1:0] r_out_exp;
    logic                   r_out_sat;

    logic                   w_accept;
    logic [EXT_W-1:0]       w_idx_ext;
    logic [INDEX_BITS-1:0]  w_idx;
    logic                   w_exp_done;
    logic [INDEX_BITS-1:0]  w_exp_val;
    logic                   w_mul_start;
    logic [MUL_BITS-1:0]    w_mul_b;
    logic                   w_mul_done;
    logic [PW-1:0]          w_prod;
    logic [PW-1:0]          w_shift;
    logic                   w_slot_free;
    logic [XW-1:0]          w_exp_ext;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_idx_ext   = EXT_W'(i_restart_index);
    assign w_idx       = w_idx_ext[INDEX_BITS-1:0];
    assign w_shift     = w_prod >> FRAC_BITS;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_exp_ext   = XW'(r_exp);

    // Multiply by the factor while steps remain, else by the base interval
    assign w_mul_start = (r_state == S_PCHK);
    assign w_mul_b     = (r_cnt == '0) ? MUL_BITS'(r_base) : MUL_BITS'(r_gf);

    lrl_luby #(
        .INDEX_BITS (INDEX_BITS)
    ) u_luby (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_luby_mode (r_luby_mode),
        .i_index     (w_idx),
        .o_done      (w_exp_done),
        .o_exponent  (w_exp_val)
    );

    lrl_smul #(
        .ACC_W (ACC_W)
    ) u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_acc),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luby_mode <= RST_LUBY_MODE;
            r_base      <= RST_BASE;
            r_gf        <= RST_GROWTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LUBY_MODE: r_luby_mode <= i_cfg_data[0];
                CFG_BASE:      r_base      <= i_cfg_data[BASE_BITS-1:0];
                CFG_GROWTH:    r_gf        <= i_cfg_data[GF_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequence exponent, power steps and final scaling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // raise valid when a result is stored, drop it once taken
            if (r_state == S_OUT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (w_exp_done) begin
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    r_state <= (r_cnt == '0) ? S_LMUL : S_PMUL;
                end
                S_PMUL: begin
                    if (w_mul_done) begin
                        r_state <= S_PCHK;
                    end
                end
                S_LMUL: begin
                    if (w_mul_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        // datapath registers
        if (r_state == S_EXP && w_exp_done) begin
            r_exp <= w_exp_val;
            r_cnt <= w_exp_val;
            r_acc <= ACC_ONE;
        end
        if (r_state == S_PMUL && w_mul_done) begin
            // clamp at the cap, stop at a fixed point, else advance
            if (w_shift >= PW'(ACC_CAP)) begin
                r_acc <= ACC_CAP;
                r_cnt <= '0;
            end else if (w_shift == PW'(r_acc)) begin
                r_cnt <= '0;
            end else begin
                r_acc <= w_shift[ACC_W-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (r_state == S_LMUL && w_mul_done) begin
            if (w_shift > PW'(LIMIT_MAX)) begin
                r_lim <= LIMIT_MAX;
                r_sat <= 1'b1;
            end else begin
                r_lim <= w_shift[LIMIT_BITS-1:0];
                r_sat <= 1'b0;
            end
        end
        if (r_state == S_OUT && w_slot_free) begin
            r_out_limit <= r_lim;
            r_out_exp   <= w_exp_ext[EXP_OUT_BITS-1:0];
            r_out_sat   <= r_sat;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_conflict_limit = r_out_limit;
    assign o_exponent       = r_out_exp;
    assign o_saturated      = r_out_sat;

    `ASSERT_CLK(a_mul_done_state, i_clk, i_rst_n, w_mul_done |-> (r_state == S_PMUL || r_state == S_LMUL), "multiply result arrived outside a multiply state")
    `ASSERT_CLK(a_acc_capped, i_clk, i_rst_n, (r_state == S_PCHK) |-> (r_acc <= ACC_CAP), "power accumulator above cap")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the restart conflict limit generator.
`timescale 1ns / 1ps

module tb_top;
    import lrl_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam longint unsigned POWER_CAP = 64'd1 << (LIMIT_BITS + FRAC);
    // smallest power * base product that still truncates to the largest limit
    localparam longint unsigned TOP_PRODUCT = POWER_CAP - (64'd1 << FRAC);
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [LIMIT_BITS-1:0]   limit;
        logic [EXP_OUT_BITS-1:0] exponent;
        logic                    saturated;
    } t_limit_result;

    typedef struct {
        bit [IDX_IN_BITS-1:0] idx;
        t_limit_result        res;
    } t_due_limit;

    // Tracks the register settings and the limits still owed by the block.
    class limit_tracker;
        bit                 luby_mode;
        bit [BASE_BITS-1:0] base_interval;
        bit [GF_BITS-1:0]   growth_factor;
        t_due_limit         limits_due[$];
        int                 failures;
        int                 mismatches;

        function new();
            luby_mode     = RST_LUBY_MODE;
            base_interval = RST_BASE;
            growth_factor = RST_GROWTH;
            failures      = 0;
            mismatches    = 0;
        endfunction

        // Find the enclosing 2^k-1 run, then fold the index down into it.
        static function longint unsigned luby_exponent(longint unsigned x);
            longint unsigned run_len;
            longint unsigned level;
            run_len = 1;
            level   = 0;
            while (run_len < x + 1) begin
                level++;
                run_len = 2 * run_len + 1;
            end
            while (run_len - 1 != x) begin
                run_len = (run_len - 1) >> 1;
                level--;
                if (run_len == 0)
                    break;
                x = x % run_len;
            end
            return level;
        endfunction

        // Raise the growth factor to e with truncating fixed-point steps.
        static function longint unsigned power_of(bit [GF_BITS-1:0] gf, longint unsigned e);
            longint unsigned acc;
            longint unsigned nxt;
            longint unsigned i;
            acc = 64'd1 << FRAC;
            for (i = 0; i < e; i++) begin
                nxt = (acc * gf) >> FRAC;
                if (nxt >= POWER_CAP) begin
                    acc = POWER_CAP;
                    break;
                end
                if (nxt == acc)
                    break;
                acc = nxt;
            end
            return acc;
        endfunction

        function t_limit_result predict(bit [IDX_IN_BITS-1:0] idx);
            t_limit_result   res;
            longint unsigned e;
            longint unsigned lim;
            e   = luby_mode ? luby_exponent(idx) : longint'(idx);
            lim = (power_of(growth_factor, e) * base_interval) >> FRAC;
            res.saturated = (lim > LIMIT_MAX);
            if (res.saturated)
                lim = LIMIT_MAX;
            res.limit    = lim[LIMIT_BITS-1:0];
            res.exponent = e[EXP_OUT_BITS-1:0];
            return res;
        endfunction

        function void note_request(bit [IDX_IN_BITS-1:0] idx);
            t_due_limit entry;
            entry.idx = idx;
            entry.res = predict(idx);
            limits_due.push_back(entry);
        endfunction

        function void check_result(t_limit_result got);
            t_due_limit want;
            if (limits_due.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: limit %0d exponent %0d saturated %0b",
                             got.limit, got.exponent, got.saturated);
                return;
            end
            want = limits_due.pop_front();
            if (got.limit !== want.res.limit || got.exponent !== want.res.exponent ||
                got.saturated !== want.res.saturated) begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("restart %0d: limit %0d/%0d exponent %0d/%0d sat %0b/%0b %s",
                             want.idx, want.res.limit, got.limit, want.res.exponent,
                             got.exponent, want.res.saturated, got.saturated,
                             "(expected/actual)");
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    t_cfg_idx                i_cfg_idx = CFG_LUBY_MODE;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic [IDX_IN_BITS-1:0]  i_restart_index = '0;
    logic                    i_out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [LIMIT_BITS-1:0]   o_conflict_limit;
    logic [EXP_OUT_BITS-1:0] o_exponent;
    logic                    o_saturated;

    limit_tracker tracker;
    bit           calm = 1'b0;
    int           stall_left = 0;
    int           idle_cycles = 0;

    luby_restart_limit_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_restart_index  (i_restart_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_conflict_limit (o_conflict_limit),
        .o_exponent       (o_exponent),
        .o_saturated      (o_saturated)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Stall the result side at random unless the phase runs calm.
    always @(posedge i_clk) begin
        if (!calm && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = pick_gap();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check every accepted result against the oldest owed limit.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            tracker.check_result({o_conflict_limit, o_exponent, o_saturated});
    end

    // Give up when neither side moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("[luby_restart_limit_top] ERROR");
            $finish;
        end
    end

    // Offer one request, hold it until taken, then maybe leave a gap.
    task automatic send_request(input bit [IDX_IN_BITS-1:0] idx);
        int gap;
        gap = calm ? 0 : pick_gap();
        i_in_valid      <= 1'b1;
        i_restart_index <= idx;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        tracker.note_request(idx);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed limit has come back.
    task automatic wait_all_limits();
        i_in_valid <= 1'b0;
        while (tracker.limits_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers; junk in the unused data bits must be ignored.
    task automatic load_settings(input bit mode, input bit [BASE_BITS-1:0] base,
                                 input bit [GF_BITS-1:0] gf);
        bit [31:0] junk;
        junk = $urandom;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LUBY_MODE;
        i_cfg_data <= {junk[CFG_BITS-2:0], mode};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BASE;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GROWTH;
        i_cfg_data <= {junk[CFG_BITS-GF_BITS-1:0], gf};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.luby_mode     = mode;
        tracker.base_interval = base;
        tracker.growth_factor = gf;
    endtask

    // Corner cases: reset settings, saturation, fixed and shrinking power, zero base, an exact maximum limit.
    task automatic run_directed();
        bit [IDX_IN_BITS-1:0] luby_points[10] = '{16'd0, 16'd1, 16'd2, 16'd6, 16'd7,
                                                  16'd14, 16'd65534, 16'd65535,
                                                  16'h5555, 16'hAAAA};
        bit [IDX_IN_BITS-1:0] steep_points[4] = '{16'd1, 16'd2, 16'd3, 16'd65535};
        int                   e_try;
        int                   g_try;
        longint unsigned      acc;
        longint unsigned      b;
        bit                   found;
        int                   hit_e;
        int                   hit_g;
        longint unsigned      hit_b;

        foreach (luby_points[i])
            send_request(luby_points[i]);

        // steepest growth, largest base: saturates from exponent 3, caps later
        wait_all_limits();
        load_settings(1'b0, 20'hFFFFF, 16'hFFFF);
        foreach (steep_points[i])
            send_request(steep_points[i]);

        // factor of exactly 1.0 holds the power fixed
        wait_all_limits();
        load_settings(1'b0, 20'hFFFFF, 16'd4096);
        send_request(16'd65535);

        // zero base interval gives zero without the flag
        wait_all_limits();
        load_settings(1'b1, 20'd0, 16'hFFFF);
        send_request(16'd65534);

        // zero factor collapses the power
        wait_all_limits();
        load_settings(1'b0, 20'hFFFFF, 16'd0);
        send_request(16'd3);

        // factor just under 1.0 shrinks by truncation
        wait_all_limits();
        load_settings(1'b0, 20'd777, 16'd4095);
        send_request(16'd40);

        // search a setting whose limit lands exactly on the maximum
        found = 1'b0;
        for (e_try = 3; e_try <= 8 && !found; e_try++) begin
            for (g_try = 65535; g_try >= 16384 && !found; g_try--) begin
                acc = limit_tracker::power_of(g_try[GF_BITS-1:0], e_try);
                if (acc >= (64'd1 << 23) && acc < POWER_CAP) begin
                    b = (TOP_PRODUCT + acc - 1) / acc;
                    if (b <= 64'hFFFFF && ((acc * b) >> FRAC) == LIMIT_MAX) begin
                        found = 1'b1;
                        hit_e = e_try;
                        hit_g = g_try;
                        hit_b = b;
                    end
                end
            end
        end
        if (found) begin
            wait_all_limits();
            load_settings(1'b0, hit_b[BASE_BITS-1:0], hit_g[GF_BITS-1:0]);
            send_request(hit_e[IDX_IN_BITS-1:0]);
        end

        // smallest base with a factor just over 1.0
        wait_all_limits();
        load_settings(1'b1, 20'd1, 16'd4097);
        send_request(16'd65535);
    endtask

    initial begin
        bit                   mode;
        bit [BASE_BITS-1:0]   base;
        bit [GF_BITS-1:0]     gf;
        bit                   cheap;
        int                   k;
        bit [IDX_IN_BITS-1:0] idx;

        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_all_limits();
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0:       base = 20'd1;
                1:       base = 20'hFFFFF;
                2:       base = 20'd0;
                3, 4:    base = BASE_BITS'($urandom_range(1, 1000));
                default: base = BASE_BITS'($urandom_range(1, 20'hFFFFF));
            endcase
            case ($urandom_range(0, 9))
                0:       gf = 16'd4096;
                1:       gf = 16'hFFFF;
                2:       gf = GF_BITS'($urandom_range(0, 4095));
                3:       gf = GF_BITS'($urandom_range(4097, 8192));
                default: gf = GF_BITS'($urandom_range(0, 65535));
            endcase
            load_settings(mode, base, gf);
            calm = ($urandom_range(0, 3) == 0);
            // these factors end the power loop within a few dozen steps
            cheap = (gf >= 16'd16384 || gf == 16'd4096 || gf <= 16'd2048);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (mode) begin
                    case ($urandom_range(0, 3))
                        0, 1: idx = IDX_IN_BITS'($urandom_range(0, 65535));
                        2: begin
                            k   = $urandom_range(1, IDX_IN_BITS);
                            idx = IDX_IN_BITS'((32'd1 << k) - 1 - $urandom_range(0, 2));
                        end
                        default: idx = IDX_IN_BITS'($urandom_range(0, 255));
                    endcase
                end else if (cheap && $urandom_range(0, 1) == 0) begin
                    idx = IDX_IN_BITS'($urandom_range(0, 65535));
                end else begin
                    idx = IDX_IN_BITS'($urandom_range(0, 63));
                end
                // now and then hold the sender until the block runs dry
                if ($urandom_range(0, 39) == 0)
                    wait_all_limits();
                send_request(idx);
            end
        end

        calm = 1'b0;
        wait_all_limits();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0)
            $display("[luby_restart_limit_top] OK");
        else
            $display("[luby_restart_limit_top] ERROR");
        $finish;
    end

endmodule
